>>> rtl/core/llapr_pkg.sv
`timescale 1ns / 1ps

package llapr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 605;
    localparam int COUNT_W = 10;

    localparam logic [7:0] ESC_BYTE     = 8'h00;
    localparam logic [7:0] ESC_LITERAL  = 8'hFF;
    localparam logic [7:0] ESC_END      = 8'hFD;
    localparam logic [7:0] ESC_FRAMEERR = 8'hFE;
    localparam logic [7:0] ESC_ABORT    = 8'hFA;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REF = 16'h8408;
    localparam logic [15:0] CRC_GOOD     = 16'hF0B8;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_GOOD  = 3'd1,
        EV_BAD   = 3'd2,
        EV_FERR  = 3'd3,
        EV_ABORT = 3'd4
    } event_t;

    typedef struct packed {
        logic                 data_valid;
        logic [7:0]           data_byte;
        logic                 overflow;
        event_t               event_res;
        logic [COUNT_W-1:0]   frame_length;
    } result_t;

endpackage

>>> rtl/core/escaped_llap_frame_receiver.sv
`timescale 1ns / 1ps

// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------------------
// rx       | rx_valid / rx_stall      | rx_byte
// res      | res_valid / res_stall    | data_valid data_byte overflow event_res
//          |                          | frame_length
//
// one word per cycle while res_stall is low; rx to res via input and result register
// the escape, crc and length state updates as a word leaves the input register
// rst_n clears valids, escape flag, length count and sets the crc to all ones
// rx_stall rises only when both registers are full and res_stall is high

module escaped_llap_frame_receiver
    import llapr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    input  logic               res_stall,
    output logic               data_valid,
    output logic [7:0]         data_byte,
    output logic               overflow,
    output logic [2:0]         event_res,
    output logic [COUNT_W-1:0] frame_length
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    result;
    logic       out_take;
    logic       in_take;
    logic       step;

    assign out_take = !out_valid_reg || !res_stall;
    assign in_take  = !in_valid_reg || out_take;
    assign step     = in_valid_reg && out_take;
    assign rx_stall = !in_take;

    llapr_decode #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (in_byte_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= rx_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign res_valid    = out_valid_reg;
    assign data_valid   = out_reg.data_valid;
    assign data_byte    = out_reg.data_byte;
    assign overflow     = out_reg.overflow;
    assign event_res    = out_reg.event_res;
    assign frame_length = out_reg.frame_length;

endmodule

>>> rtl/core/llapr_crc8.sv
`timescale 1ns / 1ps

module llapr_crc8
    import llapr_pkg::*;
(
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY_REF;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

>>> rtl/core/llapr_decode.sv
`timescale 1ns / 1ps

module llapr_decode
    import llapr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] word,
    output result_t    result
);

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAME_BYTES);

    logic               escape_reg;
    logic               escape_next;
    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic [7:0]  fold_byte;
    logic [15:0] crc_folded;

    llapr_crc8 u_crc8 (
        .crc     (crc_reg),
        .data    (fold_byte),
        .crc_out (crc_folded)
    );

    assign fold_byte = escape_reg ? ESC_BYTE : word;

    always_comb
    begin
        logic take;
        logic finish;
        event_t ev;
        take        = 1'b0;
        finish      = 1'b0;
        ev          = EV_NONE;
        escape_next = 1'b0;
        if (escape_reg)
        begin
            case (word)
                ESC_LITERAL:  take = 1'b1;
                ESC_END:
                begin
                    finish = 1'b1;
                    ev     = (crc_reg == CRC_GOOD) ? EV_GOOD : EV_BAD;
                end
                ESC_FRAMEERR:
                begin
                    finish = 1'b1;
                    ev     = EV_FERR;
                end
                ESC_ABORT:
                begin
                    finish = 1'b1;
                    ev     = EV_ABORT;
                end
                default:      take = 1'b0;
            endcase
        end
        else if (word == ESC_BYTE)
        begin
            escape_next = 1'b1;
        end
        else
        begin
            take = 1'b1;
        end

        result     = '0;
        crc_next   = crc_reg;
        count_next = count_reg;
        if (take)
        begin
            crc_next = crc_folded;
            if (count_reg < MAX_COUNT)
            begin
                count_next        = count_reg + COUNT_W'(1);
                result.data_valid = 1'b1;
                result.data_byte  = fold_byte;
            end
            else
            begin
                result.overflow = 1'b1;
            end
        end
        if (finish)
        begin
            result.event_res    = ev;
            result.frame_length = count_reg;
            crc_next            = CRC_INIT;
            count_next          = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= 1'b0;
            crc_reg    <= CRC_INIT;
            count_reg  <= '0;
        end
        else if (step)
        begin
            escape_reg <= escape_next;
            crc_reg    <= crc_next;
            count_reg  <= count_next;
        end
    end

endmodule
